// ----- rtl/tape_block_frame_parser_top_macros.svh -----
// assertion macros for the tape block frame parser
`ifndef TAPE_BLOCK_FRAME_PARSER_TOP_MACROS_SVH
`define TAPE_BLOCK_FRAME_PARSER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define TBFP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define TBFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tbfp_pkg.sv -----
// types and constants of the tape block frame parser
package tbfp_pkg;

	localparam int unsigned SYNC_LENGTH  = 15;
	localparam int unsigned HEADER_BYTES = 4;

	localparam logic [15:0] LOAD_ADDR_RESET = 16'h0801;
	localparam logic [7:0]  SUBST_BYTE      = 8'h69;
	localparam logic [7:0]  BAD_CHECK_BYTE  = 8'hFF;
	localparam logic [15:0] ERR_COUNT_MAX   = 16'hFFFF;

	typedef enum logic [2:0] {
		EV_IDLE        = 3'd0,
		EV_SYNC_FAIL   = 3'd1,
		EV_HDR_REJECT  = 3'd2,
		EV_HDR_BYTE    = 3'd3,
		EV_PAYLOAD     = 3'd4,
		EV_BLOCK_DONE  = 3'd5
	} event_t;

	typedef enum logic [4:0] {
		PH_IDLE    = 5'b00001,
		PH_SYNC    = 5'b00010,
		PH_HEADER  = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_CHECK   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [7:0] tape_byte;
		logic       byte_error;
		logic       frame_start;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [7:0]  payload_byte;
		logic [15:0] payload_offset;
		logic [15:0] load_address;
		logic [15:0] last_address;
		logic [7:0]  checksum_expected;
		logic [7:0]  checksum_read;
		logic        checksum_ok;
		logic [15:0] error_count;
		logic        last;
	} out_beat_t;

endpackage

// ----- rtl/tape_block_frame_parser_top.sv -----
// tape block frame parser: sync check, header check, payload and checksum
//
// Each accepted input beat yields exactly one result beat, registered in
// the output register. All per-byte work (sync compare, header capture and
// address check, payload substitution, checksum and error count update) is a
// single combinational pass from the input port into the state registers and
// the output register, so a new beat is taken every cycle while the output
// register is empty or being drained. The configuration port is always ready;
// write the required load address only while the parser is idle.
`include "tape_block_frame_parser_top_macros.svh"

module tape_block_frame_parser_top
	import tbfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_beat_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_beat_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	// state registers
	phase_t      phase_q;
	logic [3:0]  sync_idx_q;
	logic [7:0]  hdr_byte_q [3];
	logic [16:0] bytes_left_q;
	logic [15:0] byte_off_q;
	logic [7:0]  sum_q;
	logic [15:0] err_cnt_q;
	logic [15:0] hdr_load_q;
	logic [15:0] hdr_last_q;
	logic [15:0] req_load_q;

	logic        out_valid_q;
	out_beat_t   out_data_q;

	// next-state and result
	phase_t      phase_d;
	logic [3:0]  sync_idx_d;
	logic [16:0] bytes_left_d;
	logic [15:0] byte_off_d;
	logic [7:0]  sum_d;
	logic [15:0] err_cnt_d;
	logic [15:0] hdr_load_d;
	logic [15:0] hdr_last_d;
	logic        hdr_wr;
	out_beat_t   res;

	// values seen by this beat, after a frame start clears the frame
	phase_t      ph_cur;
	logic [3:0]  idx_cur;
	logic [7:0]  sum_cur;
	logic [15:0] err_cur;
	logic [7:0]  sync_want;
	logic [15:0] new_load;
	logic [15:0] new_last;
	logic        accept;

	assign accept    = in_valid && in_ready;
	assign in_ready  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign cfg_ready = 1'b1;

	// effective frame state for the incoming beat
	always_comb begin
		ph_cur  = in_data.frame_start ? PH_SYNC : phase_q;
		idx_cur = in_data.frame_start ? 4'd0 : sync_idx_q;
		sum_cur = in_data.frame_start ? 8'd0 : sum_q;
		err_cur = in_data.frame_start ? 16'd0 : err_cnt_q;
	end

	assign sync_want = 8'(SYNC_LENGTH - 1) - {4'd0, idx_cur};
	assign new_load  = {hdr_byte_q[1], hdr_byte_q[0]};
	assign new_last  = {in_data.tape_byte, hdr_byte_q[2]} - 16'd1;

	// per-beat update
	always_comb begin
		phase_d      = ph_cur;
		sync_idx_d   = idx_cur;
		bytes_left_d = in_data.frame_start ? 17'd0 : bytes_left_q;
		byte_off_d   = in_data.frame_start ? 16'd0 : byte_off_q;
		sum_d        = sum_cur;
		err_cnt_d    = err_cur;
		hdr_load_d   = in_data.frame_start ? 16'd0 : hdr_load_q;
		hdr_last_d   = in_data.frame_start ? 16'd0 : hdr_last_q;
		hdr_wr       = 1'b0;
		res          = '0;
		res.event_res = EV_IDLE;

		unique case (ph_cur)
			PH_SYNC: begin
				if (in_data.byte_error || in_data.tape_byte != sync_want) begin
					res.event_res = EV_SYNC_FAIL;
					phase_d       = PH_IDLE;
				end else if (idx_cur == 4'(SYNC_LENGTH - 1)) begin
					sync_idx_d = 4'd0;
					phase_d    = PH_HEADER;
				end else begin
					sync_idx_d = idx_cur + 4'd1;
				end
			end
			PH_HEADER: begin
				if (in_data.byte_error) begin
					res.event_res = EV_HDR_REJECT;
					phase_d       = PH_IDLE;
				end else if (idx_cur[1:0] != 2'(HEADER_BYTES - 1)) begin
					hdr_wr        = 1'b1;
					sync_idx_d    = idx_cur + 4'd1;
					res.event_res = EV_HDR_BYTE;
				end else begin
					sync_idx_d       = 4'd0;
					hdr_load_d       = new_load;
					hdr_last_d       = new_last;
					res.load_address = new_load;
					res.last_address = new_last;
					if (new_last < new_load || new_load != req_load_q) begin
						res.event_res = EV_HDR_REJECT;
						phase_d       = PH_IDLE;
					end else begin
						res.event_res = EV_HDR_BYTE;
						bytes_left_d  = {1'b0, new_last} - {1'b0, new_load} + 17'd1;
						byte_off_d    = 16'd0;
						phase_d       = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				res.event_res = EV_PAYLOAD;
				if (in_data.byte_error) begin
					res.payload_byte = SUBST_BYTE;
					if (err_cur != ERR_COUNT_MAX) begin
						err_cnt_d = err_cur + 16'd1;
					end
				end else begin
					res.payload_byte = in_data.tape_byte;
					sum_d            = sum_cur + in_data.tape_byte + 8'd1;
				end
				res.payload_offset = byte_off_q;
				byte_off_d         = byte_off_q + 16'd1;
				bytes_left_d       = bytes_left_q - 17'd1;
				if (bytes_left_q == 17'd1) begin
					phase_d = PH_CHECK;
				end
				res.load_address      = hdr_load_q;
				res.last_address      = hdr_last_q;
				res.checksum_expected = sum_d;
				res.error_count       = err_cnt_d;
			end
			PH_CHECK: begin
				res.event_res         = EV_BLOCK_DONE;
				res.load_address      = hdr_load_q;
				res.last_address      = hdr_last_q;
				res.checksum_expected = sum_cur;
				res.error_count       = err_cur;
				res.checksum_read     = in_data.byte_error ? BAD_CHECK_BYTE
				                                            : in_data.tape_byte;
				res.checksum_ok       = !in_data.byte_error &&
				                        in_data.tape_byte == sum_cur;
				res.last              = 1'b1;
				phase_d               = PH_IDLE;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// control and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			sync_idx_q   <= 4'd0;
			bytes_left_q <= 17'd0;
			byte_off_q   <= 16'd0;
			sum_q        <= 8'd0;
			err_cnt_q    <= 16'd0;
			hdr_load_q   <= 16'd0;
			hdr_last_q   <= 16'd0;
		end else if (accept) begin
			phase_q      <= phase_d;
			sync_idx_q   <= sync_idx_d;
			bytes_left_q <= bytes_left_d;
			byte_off_q   <= byte_off_d;
			sum_q        <= sum_d;
			err_cnt_q    <= err_cnt_d;
			hdr_load_q   <= hdr_load_d;
			hdr_last_q   <= hdr_last_d;
		end
	end

	// header bytes, last one is used straight from the input
	always_ff @(posedge clk) begin
		if (accept && hdr_wr) begin
			hdr_byte_q[idx_cur[1:0]] <= in_data.tape_byte;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_load_q <= LOAD_ADDR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			req_load_q <= cfg_data;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= res;
		end
	end

	// checks
	`TBFP_ASSERT_NEXT(a_one_result, accept, out_valid_q, "accepted beat gave no result")
	`TBFP_ASSERT_NOW(a_last_done, out_valid_q, out_data_q.last == (out_data_q.event_res == EV_BLOCK_DONE), "last flag disagrees with event")
	`TBFP_ASSERT_NOW(a_payload_left, phase_q == PH_PAYLOAD, bytes_left_q != 17'd0, "payload phase with no bytes left")

endmodule
